// ----- rtl/core/cpsr_pkg.sv -----
// Shared types and constants for the code point script range lookup block.
`default_nettype none

package cpsr_pkg;

    // Field widths of the input and result beats.
    localparam int CMD_W      = 2;
    localparam int SLOT_W     = 13;
    localparam int CP_W       = 21;
    localparam int LEN_W      = 21;
    localparam int SCRIPT_W   = 8;

    // Configuration register widths.
    localparam int LIMIT_W    = 14;
    localparam int COUNT_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    // Command codes carried by the cmd field.
    localparam logic [CMD_W-1:0] CMD_LOAD_RANGE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_DIRECT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP      = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECT_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGES_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_CODE  = 2'd2;

    // Configuration reset values.
    localparam logic [LIMIT_W-1:0]  DIRECT_LIMIT_RST  = 14'd8192;
    localparam logic [COUNT_W-1:0]  RANGES_IN_USE_RST = 12'd0;
    localparam logic [SCRIPT_W-1:0] UNKNOWN_CODE_RST  = 8'd61;

    // One entry of the sorted range table.
    typedef struct packed {
        logic [CP_W-1:0]     start;
        logic [LEN_W-1:0]    length;
        logic [SCRIPT_W-1:0] script;
    } range_entry_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIRECT,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_range;
        logic load_direct;
        logic start_search;
        logic take_direct;
        logic search_step;
        logic take_miss;
        logic emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_direct;
        logic count_zero;
        logic hit;
        logic more;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/cpsr_ctrl.sv -----
// Controller state machine that sequences loads, direct reads and range searches.
`default_nettype none

module cpsr_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic [cpsr_pkg::CMD_W-1:0]   in_cmd,
    input  wire cpsr_pkg::dp_status_t         status,
    output logic                              in_stall,
    output cpsr_pkg::ctrl_cmd_t               cmd_out
);

    cpsr_pkg::state_t state_reg;
    cpsr_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cpsr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd_out    = '0;
        in_stall   = 1'b1;

        unique case (state_reg)
            cpsr_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    unique case (in_cmd)
                        cpsr_pkg::CMD_LOAD_RANGE:
                        begin
                            cmd_out.load_range = 1'b1;
                        end
                        cpsr_pkg::CMD_LOAD_DIRECT:
                        begin
                            cmd_out.load_direct = 1'b1;
                        end
                        cpsr_pkg::CMD_LOOKUP:
                        begin
                            priority if (status.in_direct)
                            begin
                                state_next = cpsr_pkg::ST_DIRECT;
                            end
                            else if (status.count_zero)
                            begin
                                cmd_out.take_miss = 1'b1;
                                state_next        = cpsr_pkg::ST_EMIT;
                            end
                            else
                            begin
                                cmd_out.start_search = 1'b1;
                                state_next           = cpsr_pkg::ST_SEARCH;
                            end
                        end
                        default:
                        begin
                            // The unused command is taken and dropped.
                            state_next = cpsr_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            cpsr_pkg::ST_DIRECT:
            begin
                // Direct table data is registered and ready now.
                cmd_out.take_direct = 1'b1;
                state_next          = cpsr_pkg::ST_EMIT;
            end

            cpsr_pkg::ST_SEARCH:
            begin
                // One probe of the range table per cycle.
                cmd_out.search_step = 1'b1;
                priority if (status.hit)
                begin
                    state_next = cpsr_pkg::ST_EMIT;
                end
                else if (!status.more)
                begin
                    cmd_out.take_miss = 1'b1;
                    state_next        = cpsr_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = cpsr_pkg::ST_SEARCH;
                end
            end

            cpsr_pkg::ST_EMIT:
            begin
                // Wait until the output register can take the result.
                if (!status.out_busy)
                begin
                    cmd_out.emit = 1'b1;
                    state_next   = cpsr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cpsr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/cpsr_dpath.sv -----
// Datapath with the direct and range tables, the search registers and the output register.
`default_nettype none

module cpsr_dpath #(
    parameter int DIRECT_DEPTH = 8192,
    parameter int RANGE_DEPTH  = 2048
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire cpsr_pkg::ctrl_cmd_t             cmd_in,
    output cpsr_pkg::dp_status_t                 status,
    input  wire logic [cpsr_pkg::SLOT_W-1:0]     slot,
    input  wire logic [cpsr_pkg::CP_W-1:0]       range_first,
    input  wire logic [cpsr_pkg::LEN_W-1:0]      range_length,
    input  wire logic [cpsr_pkg::SCRIPT_W-1:0]   script_value,
    input  wire logic [cpsr_pkg::CP_W-1:0]       codepoint,
    input  wire logic [cpsr_pkg::LIMIT_W-1:0]    direct_limit,
    input  wire logic [cpsr_pkg::COUNT_W-1:0]    ranges_in_use,
    input  wire logic [cpsr_pkg::SCRIPT_W-1:0]   unknown_code,
    input  wire logic                            out_stall,
    output logic                                 out_valid,
    output logic [cpsr_pkg::SCRIPT_W-1:0]        script_id,
    output logic                                 matched
);

    localparam int CPW = cpsr_pkg::CP_W;
    localparam int LW  = $clog2(RANGE_DEPTH);
    localparam int CW  = LW + 1;
    localparam int DW  = $clog2(DIRECT_DEPTH);
    localparam logic [CPW-1:0] DIRECT_DEPTH_CP = CPW'(DIRECT_DEPTH);
    localparam logic [CW-1:0]  RANGE_DEPTH_CNT = CW'(RANGE_DEPTH);

    // Table storage.
    cpsr_pkg::range_entry_t            range_mem [RANGE_DEPTH];
    logic [cpsr_pkg::SCRIPT_W-1:0]     direct_mem [DIRECT_DEPTH];
    cpsr_pkg::range_entry_t            range_rdata_reg;
    logic [cpsr_pkg::SCRIPT_W-1:0]     direct_rdata_reg;

    // Search state.
    logic [CPW-1:0]                    cp_reg;
    logic [CW-1:0]                     lo_reg;
    logic [CW-1:0]                     up_reg;
    logic [LW-1:0]                     mid_reg;
    logic [LW-1:0]                     last_match_reg;

    // Pending result and output register.
    logic [cpsr_pkg::SCRIPT_W-1:0]     res_script_reg;
    logic                              res_matched_reg;
    logic                              out_valid_reg;
    logic [cpsr_pkg::SCRIPT_W-1:0]     out_script_reg;
    logic                              out_matched_reg;

    logic [CW-1:0]                     n_eff;
    logic [LW-1:0]                     mid_first;
    logic                              range_slot_ok;
    logic                              direct_slot_ok;
    logic [CPW:0]                      range_end;
    logic                              cp_below;
    logic                              cp_beyond;
    logic                              probe_hit;
    logic [CW-1:0]                     lo_step;
    logic [CW-1:0]                     up_step;
    logic [CW:0]                       mid_sum;
    logic [LW-1:0]                     mid_step;
    logic [LW-1:0]                     range_raddr;

    // Range count saturated at the table depth, and the first probe.
    always_comb
    begin
        if (32'(ranges_in_use) > 32'(RANGE_DEPTH))
        begin
            n_eff = RANGE_DEPTH_CNT;
        end
        else
        begin
            n_eff = CW'(ranges_in_use);
        end

        // A stale hint falls back to the middle of the ranges in use.
        if ({1'b0, last_match_reg} < n_eff)
        begin
            mid_first = last_match_reg;
        end
        else
        begin
            mid_first = n_eff[LW:1];
        end
    end

    // Load slots beyond a table are dropped.
    assign range_slot_ok  = 32'(slot) < 32'(RANGE_DEPTH);
    assign direct_slot_ok = 32'(slot) < 32'(DIRECT_DEPTH);

    // Probe compare: the range covers start <= cp < start + length.
    assign range_end = {1'b0, range_rdata_reg.start} + {1'b0, range_rdata_reg.length};
    assign cp_below  = cp_reg < range_rdata_reg.start;
    assign cp_beyond = {1'b0, cp_reg} >= range_end;
    assign probe_hit = !cp_below && !cp_beyond;

    // Narrow the bounds; upper is kept one past the last candidate.
    always_comb
    begin
        if (cp_below)
        begin
            lo_step = lo_reg;
            up_step = {1'b0, mid_reg};
        end
        else
        begin
            lo_step = {1'b0, mid_reg} + CW'(1);
            up_step = up_reg;
        end
        mid_sum  = {1'b0, lo_step} + {1'b0, up_step} - (CW + 1)'(1);
        mid_step = mid_sum[LW:1];
    end

    // The next probe address is launched in the cycle the bounds change.
    assign range_raddr = cmd_in.start_search ? mid_first : mid_step;

    // Range table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd_in.load_range && range_slot_ok)
        begin
            range_mem[LW'(slot)] <= '{start: range_first, length: range_length,
                                      script: script_value};
        end
        range_rdata_reg <= range_mem[range_raddr];
    end

    // Direct table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd_in.load_direct && direct_slot_ok)
        begin
            direct_mem[DW'(slot)] <= script_value;
        end
        direct_rdata_reg <= direct_mem[DW'(codepoint)];
    end

    // Search bounds and probe index.
    always_ff @(posedge clk)
    begin
        if (cmd_in.start_search)
        begin
            cp_reg  <= codepoint;
            lo_reg  <= '0;
            up_reg  <= n_eff;
            mid_reg <= mid_first;
        end
        else if (cmd_in.search_step)
        begin
            lo_reg  <= lo_step;
            up_reg  <= up_step;
            mid_reg <= mid_step;
        end
    end

    // Last matching range, used as the first probe of the next search.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_match_reg <= '0;
        end
        else if (cmd_in.search_step && probe_hit)
        begin
            last_match_reg <= mid_reg;
        end
    end

    // Pending result of the lookup in progress.
    always_ff @(posedge clk)
    begin
        priority if (cmd_in.take_direct)
        begin
            res_script_reg  <= direct_rdata_reg;
            res_matched_reg <= 1'b1;
        end
        else if (cmd_in.search_step && probe_hit)
        begin
            res_script_reg  <= range_rdata_reg.script;
            res_matched_reg <= 1'b1;
        end
        else if (cmd_in.take_miss)
        begin
            res_script_reg  <= unknown_code;
            res_matched_reg <= 1'b0;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_in.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd_in.emit)
        begin
            out_script_reg  <= res_script_reg;
            out_matched_reg <= res_matched_reg;
        end
    end

    // Status toward the controller.
    always_comb
    begin
        status.in_direct  = (codepoint < {{(CPW - cpsr_pkg::LIMIT_W){1'b0}}, direct_limit})
                            && (codepoint < DIRECT_DEPTH_CP);
        status.count_zero = (n_eff == '0);
        status.hit        = probe_hit;
        status.more       = lo_step < up_step;
        status.out_busy   = out_valid_reg && out_stall;
    end

    assign out_valid = out_valid_reg;
    assign script_id = out_script_reg;
    assign matched   = out_matched_reg;

endmodule

`default_nettype wire

// ----- rtl/core/codepoint_script_range_lookup.sv -----
// Top level of the code point script range lookup block with its configuration registers.
//
// Usage: each input beat carries a command. A range load or a direct load leaves the
// block idle and gives no result beat; loads to a slot beyond their table are dropped.
// A lookup gives one result beat with script_id and matched. Code points below the
// effective direct limit read the direct table; all others run a binary search over
// the range table, one probe per cycle, starting at the range that matched last when
// that range is still in use. A search makes at most about log2(ranges in use) + 1
// probes (12 for 2048 ranges); with no ranges in use, a code point outside the direct
// range gets the unknown code without a search. The probe rate is set by the single read
// port of the range table. The input stalls while a lookup is in work. The result sits
// in an output register, so a stalled receiver does not block loads; a finished lookup
// waits for the register. Configuration is written through cfg_write, cfg_index and
// cfg_data; the user must write it only while idle, as the block itself does not
// enforce this. Reset restores the register defaults and clears the match hint and all
// handshake state; table contents are undefined until loaded.
`default_nettype none

module codepoint_script_range_lookup #(
    parameter int DIRECT_DEPTH = 8192,
    parameter int RANGE_DEPTH  = 2048
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration port.
    input  wire logic                              cfg_write,
    input  wire logic [cpsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cpsr_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Input channel.
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [cpsr_pkg::CMD_W-1:0]        cmd,
    input  wire logic [cpsr_pkg::SLOT_W-1:0]       slot,
    input  wire logic [cpsr_pkg::CP_W-1:0]         range_first,
    input  wire logic [cpsr_pkg::LEN_W-1:0]        range_length,
    input  wire logic [cpsr_pkg::SCRIPT_W-1:0]     script_value,
    input  wire logic [cpsr_pkg::CP_W-1:0]         codepoint,
    // Output channel.
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [cpsr_pkg::SCRIPT_W-1:0]          script_id,
    output logic                                   matched
);

    logic [cpsr_pkg::LIMIT_W-1:0]  direct_limit_reg;
    logic [cpsr_pkg::COUNT_W-1:0]  ranges_in_use_reg;
    logic [cpsr_pkg::SCRIPT_W-1:0] unknown_code_reg;

    cpsr_pkg::ctrl_cmd_t           ctrl_cmd;
    cpsr_pkg::dp_status_t          dp_status;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direct_limit_reg  <= cpsr_pkg::DIRECT_LIMIT_RST;
            ranges_in_use_reg <= cpsr_pkg::RANGES_IN_USE_RST;
            unknown_code_reg  <= cpsr_pkg::UNKNOWN_CODE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                cpsr_pkg::CFG_DIRECT_LIMIT:
                begin
                    direct_limit_reg <= cfg_data[cpsr_pkg::LIMIT_W-1:0];
                end
                cpsr_pkg::CFG_RANGES_IN_USE:
                begin
                    ranges_in_use_reg <= cfg_data[cpsr_pkg::COUNT_W-1:0];
                end
                cpsr_pkg::CFG_UNKNOWN_CODE:
                begin
                    unknown_code_reg <= cfg_data[cpsr_pkg::SCRIPT_W-1:0];
                end
                default:
                begin
                    // Writes to an unmapped index are ignored.
                    unknown_code_reg <= unknown_code_reg;
                end
            endcase
        end
    end

    // Sequencer.
    cpsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (cmd),
        .status   (dp_status),
        .in_stall (in_stall),
        .cmd_out  (ctrl_cmd)
    );

    // Tables, search and output register.
    cpsr_dpath #(
        .DIRECT_DEPTH (DIRECT_DEPTH),
        .RANGE_DEPTH  (RANGE_DEPTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_in        (ctrl_cmd),
        .status        (dp_status),
        .slot          (slot),
        .range_first   (range_first),
        .range_length  (range_length),
        .script_value  (script_value),
        .codepoint     (codepoint),
        .direct_limit  (direct_limit_reg),
        .ranges_in_use (ranges_in_use_reg),
        .unknown_code  (unknown_code_reg),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .script_id     (script_id),
        .matched       (matched)
    );

    // A lookup beat always keeps the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (cmd == cpsr_pkg::CMD_LOOKUP)) |=> in_stall)
        else $error("lookup did not occupy the sequencer");

    // Load beats and the unused command leave the input unstalled in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (cmd != cpsr_pkg::CMD_LOOKUP)) |=> !in_stall)
        else $error("non-lookup beat stalled the input");

    // A new result beat only appears after the sequencer was busy with a lookup.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result beat appeared without a lookup in work");

    // The sequencer never produces a result beat while the output register is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && ctrl_cmd.emit) |-> 1'b0)
        else $error("result overwrote a stalled output beat");

endmodule

`default_nettype wire

// ----- tb/codepoint_script_range_lookup_tb.sv -----
// Self-checking testbench for the code point script range lookup block.
`timescale 1ns / 100ps

module codepoint_script_range_lookup_tb;

    localparam int DIRECT_DEPTH  = 8192;
    localparam int RANGE_DEPTH   = 2048;
    localparam int DIRECT_IDX_W  = $clog2(DIRECT_DEPTH);
    localparam int RANGE_IDX_W   = $clog2(RANGE_DEPTH);
    localparam int SLOT_MAX      = 8191;
    localparam int CP_MAX        = 1114111;
    localparam int LEN_MAX       = 1114112;
    localparam int RANGE_PITCH   = 544;
    localparam int SETTLE_CYCLES = 24;
    localparam int IDLE_LIMIT    = 3000;
    localparam int HOLD_CYCLES   = 400;

    typedef logic [cpsr_pkg::CMD_W-1:0]      cmd_t;
    typedef logic [cpsr_pkg::SLOT_W-1:0]     slot_t;
    typedef logic [cpsr_pkg::CP_W-1:0]       cp_t;
    typedef logic [cpsr_pkg::LEN_W-1:0]      len_t;
    typedef logic [cpsr_pkg::SCRIPT_W-1:0]   script_t;
    typedef logic [cpsr_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [cpsr_pkg::CFG_DATA_W-1:0] cfg_data_t;

    // The one command code that the block leaves unused.
    localparam cmd_t CMD_UNUSED = 2'd3;

    typedef struct packed {
        script_t script_id;
        logic    matched;
    } lookup_result_t;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      cfg_write    = 1'b0;
    cfg_idx_t  cfg_index    = '0;
    cfg_data_t cfg_data     = '0;
    logic      in_valid     = 1'b0;
    logic      in_stall;
    cmd_t      cmd          = '0;
    slot_t     slot         = '0;
    cp_t       range_first  = '0;
    len_t      range_length = '0;
    script_t   script_value = '0;
    cp_t       codepoint    = '0;
    logic      out_valid;
    logic      out_stall    = 1'b0;
    script_t   script_id;
    logic      matched;

    // Shadow copy of the block's registers, tables and match hint.
    logic [cpsr_pkg::LIMIT_W-1:0] direct_limit_reg = cpsr_pkg::DIRECT_LIMIT_RST;
    logic [cpsr_pkg::COUNT_W-1:0] range_count_reg  = cpsr_pkg::RANGES_IN_USE_RST;
    script_t                      unknown_reg      = cpsr_pkg::UNKNOWN_CODE_RST;
    script_t                      direct_table [DIRECT_DEPTH];
    cp_t                          range_start_tbl [RANGE_DEPTH];
    len_t                         range_len_tbl [RANGE_DEPTH];
    script_t                      range_script_tbl [RANGE_DEPTH];
    int                           match_hint = 0;

    lookup_result_t pending_scripts [$];
    int             mismatches = 0;

    // Which table entries the stimulus has already written.
    bit direct_loaded [DIRECT_DEPTH];
    bit range_loaded [RANGE_DEPTH];

    // Idling controls shared by the sender, the receiver and the tests.
    bit tx_gaps_on   = 1'b1;
    bit rx_stalls_on = 1'b1;
    int hold_left    = 0;

    codepoint_script_range_lookup #(
        .DIRECT_DEPTH(DIRECT_DEPTH),
        .RANGE_DEPTH (RANGE_DEPTH)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .slot        (slot),
        .range_first (range_first),
        .range_length(range_length),
        .script_value(script_value),
        .codepoint   (codepoint),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .script_id   (script_id),
        .matched     (matched)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Effective direct limit, clipped to the table depth.
    function automatic int direct_bound();
        return (direct_limit_reg > DIRECT_DEPTH) ? DIRECT_DEPTH : int'(direct_limit_reg);
    endfunction

    // Number of ranges searched, saturated at the table depth.
    function automatic int searched_count();
        return (range_count_reg > RANGE_DEPTH) ? RANGE_DEPTH : int'(range_count_reg);
    endfunction

    // Binary search over the ranges in use, starting at the last matching range.
    function automatic bit search_ranges_for(input cp_t cp, output script_t found);
        int          n;
        int          lower;
        int          upper;
        int          mid;
        int unsigned first_cp;
        int unsigned end_cp;
        found = '0;
        n = searched_count();
        if (n == 0)
            return 1'b0;
        lower = 0;
        upper = n - 1;
        mid = (match_hint < n) ? match_hint : n / 2;
        do
        begin
            first_cp = range_start_tbl[mid];
            // The end is formed in 32 bits so that it never wraps.
            end_cp = first_cp + range_len_tbl[mid];
            if (cp < first_cp)
                upper = mid - 1;
            else if (cp >= end_cp)
                lower = mid + 1;
            else
            begin
                match_hint = mid;
                found = range_script_tbl[mid];
                return 1'b1;
            end
            mid = (lower + upper) / 2;
        end
        while (lower <= upper);
        return 1'b0;
    endfunction

    // Walks the same search without side effects and gives the first probed
    // entry that was never written, or -1 when every probe is defined.
    function automatic int first_undefined_probe(input cp_t cp);
        int          n;
        int          lower;
        int          upper;
        int          mid;
        int unsigned first_cp;
        int unsigned end_cp;
        n = searched_count();
        if (n == 0)
            return -1;
        lower = 0;
        upper = n - 1;
        mid = (match_hint < n) ? match_hint : n / 2;
        do
        begin
            if (!range_loaded[mid])
                return mid;
            first_cp = range_start_tbl[mid];
            end_cp = first_cp + range_len_tbl[mid];
            if (cp < first_cp)
                upper = mid - 1;
            else if (cp >= end_cp)
                lower = mid + 1;
            else
                return -1;
            mid = (lower + upper) / 2;
        end
        while (lower <= upper);
        return -1;
    endfunction

    // Applies one accepted beat to the shadow state and queues its result.
    function automatic void predict_script(input cmd_t    beat_cmd,
                                           input slot_t   beat_slot,
                                           input cp_t     beat_first,
                                           input len_t    beat_length,
                                           input script_t beat_script,
                                           input cp_t     beat_cp);
        lookup_result_t res;
        script_t        found;
        case (beat_cmd)
            cpsr_pkg::CMD_LOAD_RANGE:
            begin
                if (beat_slot < RANGE_DEPTH)
                begin
                    range_start_tbl[beat_slot[RANGE_IDX_W-1:0]]  = beat_first;
                    range_len_tbl[beat_slot[RANGE_IDX_W-1:0]]    = beat_length;
                    range_script_tbl[beat_slot[RANGE_IDX_W-1:0]] = beat_script;
                end
            end
            cpsr_pkg::CMD_LOAD_DIRECT:
            begin
                if (beat_slot < DIRECT_DEPTH)
                    direct_table[beat_slot[DIRECT_IDX_W-1:0]] = beat_script;
            end
            cpsr_pkg::CMD_LOOKUP:
            begin
                if (beat_cp < direct_bound())
                begin
                    res.script_id = direct_table[beat_cp[DIRECT_IDX_W-1:0]];
                    res.matched   = 1'b1;
                end
                else if (search_ranges_for(beat_cp, found))
                begin
                    res.script_id = found;
                    res.matched   = 1'b1;
                end
                else
                begin
                    res.script_id = unknown_reg;
                    res.matched   = 1'b0;
                end
                pending_scripts.push_back(res);
            end
            default:
            begin
            end
        endcase
    endfunction

    // Result check, register shadowing and prediction, all on the rising edge.
    always @(posedge clk)
    begin : check_and_predict
        lookup_result_t want;
        if (out_valid && !out_stall)
        begin
            if (pending_scripts.size() == 0)
            begin
                $error("result beat with no lookup pending: script_id %0d matched %0d",
                       script_id, matched);
                mismatches++;
            end
            else
            begin
                want = pending_scripts.pop_front();
                if (script_id !== want.script_id)
                begin
                    $error("script_id: expected %0d, got %0d", want.script_id, script_id);
                    mismatches++;
                end
                if (matched !== want.matched)
                begin
                    $error("matched: expected %0d, got %0d", want.matched, matched);
                    mismatches++;
                end
            end
        end
        if (cfg_write)
        begin
            case (cfg_index)
                cpsr_pkg::CFG_DIRECT_LIMIT:
                    direct_limit_reg = cfg_data[cpsr_pkg::LIMIT_W-1:0];
                cpsr_pkg::CFG_RANGES_IN_USE:
                    range_count_reg = cfg_data[cpsr_pkg::COUNT_W-1:0];
                cpsr_pkg::CFG_UNKNOWN_CODE:
                    unknown_reg = cfg_data[cpsr_pkg::SCRIPT_W-1:0];
                default:
                begin
                end
            endcase
        end
        if (in_valid && !in_stall)
            predict_script(cmd, slot, range_first, range_length, script_value, codepoint);
    end

    // Receiver: random stall runs, a forced hold when a test asks for one.
    initial
    begin : receiver
        int run_left;
        int r;
        run_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!rx_stalls_on)
                out_stall <= 1'b0;
            else if (run_left > 0)
            begin
                run_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 20)
                begin
                    run_left = (r < 2) ? $urandom_range(10, 40) : $urandom_range(0, 2);
                    out_stall <= 1'b1;
                end
                else
                    out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("codepoint_script_range_lookup_tb NOT OK");
        $finish;
    end

    function automatic int rand_cp();
        return $urandom_range(0, CP_MAX);
    endfunction

    function automatic int rand_len();
        return $urandom_range(0, LEN_MAX);
    endfunction

    function automatic int rand_script();
        return $urandom_range(0, 255);
    endfunction

    // Sender gap: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offers one beat from a falling edge and returns at a falling edge after acceptance.
    task automatic send_beat(input cmd_t    beat_cmd,
                             input slot_t   beat_slot,
                             input cp_t     beat_first,
                             input len_t    beat_length,
                             input script_t beat_script,
                             input cp_t     beat_cp);
        int gap;
        in_valid     <= 1'b1;
        cmd          <= beat_cmd;
        slot         <= beat_slot;
        range_first  <= beat_first;
        range_length <= beat_length;
        script_value <= beat_script;
        codepoint    <= beat_cp;
        @(posedge clk);
        while (!(in_valid && !in_stall))
            @(posedge clk);
        @(negedge clk);
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic load_range(input int s, input int first_cp, input int len, input int sv);
        send_beat(cpsr_pkg::CMD_LOAD_RANGE, slot_t'(s), cp_t'(first_cp), len_t'(len),
                  script_t'(sv), cp_t'(rand_cp()));
        if (s < RANGE_DEPTH)
            range_loaded[s] = 1'b1;
    endtask

    // Loads slot s with a range inside its own pitch cell, so such slots stay sorted.
    task automatic load_pitch_range(input int s);
        int off;
        int len;
        off = $urandom_range(0, 63);
        len = ($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, RANGE_PITCH - off);
        load_range(s, s * RANGE_PITCH + off, len, rand_script());
    endtask

    // Writes every range entry that the search for cp is about to probe.
    task automatic fill_probes(input int cp);
        int idx;
        idx = first_undefined_probe(cp_t'(cp));
        while (idx >= 0)
        begin
            load_pitch_range(idx);
            idx = first_undefined_probe(cp_t'(cp));
        end
    endtask

    task automatic load_direct(input int s, input int sv);
        send_beat(cpsr_pkg::CMD_LOAD_DIRECT, slot_t'(s), cp_t'(rand_cp()),
                  len_t'(rand_len()), script_t'(sv), cp_t'(rand_cp()));
        direct_loaded[s] = 1'b1;
    endtask

    // Lookup of one code point; the table entries it reads are written first.
    task automatic lookup(input int cp);
        if (cp < direct_bound())
        begin
            if (!direct_loaded[cp])
                load_direct(cp, rand_script());
        end
        else
            fill_probes(cp);
        send_beat(cpsr_pkg::CMD_LOOKUP, slot_t'($urandom_range(0, SLOT_MAX)),
                  cp_t'(rand_cp()), len_t'(rand_len()), script_t'(rand_script()),
                  cp_t'(cp));
    endtask

    task automatic send_unused();
        send_beat(CMD_UNUSED, slot_t'($urandom_range(0, SLOT_MAX)), cp_t'(rand_cp()),
                  len_t'(rand_len()), script_t'(rand_script()), cp_t'(rand_cp()));
    endtask

    // Stops offering beats and waits until every lookup has answered.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_scripts.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= cfg_data_t'(value);
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_config(input int limit_value, input int count_value,
                                input int unknown_value);
        drain();
        write_reg(cpsr_pkg::CFG_DIRECT_LIMIT, limit_value);
        write_reg(cpsr_pkg::CFG_RANGES_IN_USE, count_value);
        write_reg(cpsr_pkg::CFG_UNKNOWN_CODE, unknown_value);
    endtask

    // Fills slots 0 to n-1 with sorted ranges that do not overlap.
    task automatic load_sorted_ranges(input int n);
        int span;
        int off;
        int first_cp;
        int len;
        int r;
        span = (CP_MAX + 1) / n;
        for (int i = 0; i < n; i++)
        begin
            off = $urandom_range(0, span / 4);
            first_cp = i * span + off;
            r = $urandom_range(0, 99);
            if (r < 8)
                len = 0;
            else if (r < 16)
                len = 1;
            else
                len = $urandom_range(1, span - off);
            // The last range sometimes runs far past the code space.
            if (i == n - 1 && r >= 90)
                len = LEN_MAX;
            load_range(i, first_cp, len, rand_script());
        end
    endtask

    // Random mix: mostly lookups, many at range edges, plus loads, noise and pauses.
    task automatic random_items(input int count);
        int n;
        int r;
        int j;
        int cp;
        for (int k = 0; k < count; k++)
        begin
            n = searched_count();
            r = $urandom_range(0, 99);
            if (r < 45 && n > 0)
            begin
                j = $urandom_range(0, n - 1);
                if (!range_loaded[j])
                    cp = rand_cp();
                else
                begin
                    case ($urandom_range(0, 4))
                        0: cp = int'(range_start_tbl[j]) - 1;
                        1: cp = int'(range_start_tbl[j]);
                        2: cp = int'(range_start_tbl[j]) + int'(range_len_tbl[j]) - 1;
                        3: cp = int'(range_start_tbl[j]) + int'(range_len_tbl[j]);
                        default: cp = int'(range_start_tbl[j]) +
                                      $urandom_range(0, range_len_tbl[j]);
                    endcase
                end
                if (cp < 0)
                    cp = 0;
                if (cp > CP_MAX)
                    cp = CP_MAX;
                lookup(cp);
            end
            else if (r < 65)
                lookup(($urandom_range(0, 1) == 0) ? rand_cp() : $urandom_range(0, 16383));
            else if (r < 80)
                load_direct($urandom_range(0, DIRECT_DEPTH - 1), rand_script());
            else if (r < 87)
                load_range($urandom_range(RANGE_DEPTH, SLOT_MAX), rand_cp(), rand_len(),
                           rand_script());
            else if (r < 92)
                send_unused();
            else if (r < 96 && n > 0)
                load_range($urandom_range(0, n - 1), rand_cp(), rand_len(), rand_script());
            else
                drain();
        end
    endtask

    // Register defaults: direct table in full, no ranges, unused command, dropped loads.
    task automatic test_reset_defaults();
        load_direct(0, 0);
        load_direct(DIRECT_DEPTH - 1, 255);
        lookup(0);
        lookup(DIRECT_DEPTH - 1);
        lookup(DIRECT_DEPTH);
        lookup(CP_MAX);
        send_unused();
        load_range(RANGE_DEPTH, 5000, 10, 1);
        load_range(SLOT_MAX, 8192, 10, 2);
        lookup(8195);
    endtask

    // Range edges, a zero-length range and a range whose end passes 21 bits.
    task automatic test_range_edges();
        load_range(0, 8192, 100, 10);
        load_range(1, 9000, 0, 11);
        load_range(2, 10000, 1, 12);
        load_range(3, 'h100000, LEN_MAX, 255);
        write_config(cpsr_pkg::DIRECT_LIMIT_RST, 4, 0);
        lookup(8192);
        lookup(8291);
        lookup(8292);
        lookup(9000);
        lookup(10000);
        lookup(10001);
        lookup(CP_MAX);
        lookup('hFFFFF);
    endtask

    // Direct limit above the table, at zero and at one.
    task automatic test_direct_limits();
        write_config(16383, 4, 255);
        lookup(DIRECT_DEPTH - 1);
        lookup(DIRECT_DEPTH);
        write_config(0, 4, cpsr_pkg::UNKNOWN_CODE_RST);
        lookup(0);
        write_config(1, 4, 200);
        lookup(0);
        lookup(1);
    endtask

    // Several small tables under different register settings.
    task automatic test_random_tables();
        int n;
        int limit_value;
        int count_value;
        for (int round = 0; round < 6; round++)
        begin
            case (round)
                0: n = 1;
                1: n = 2;
                2: n = 3;
                3: n = $urandom_range(4, 16);
                4: n = $urandom_range(17, 64);
                default: n = $urandom_range(1, 12);
            endcase
            case (round)
                0: limit_value = cpsr_pkg::DIRECT_LIMIT_RST;
                1: limit_value = 0;
                2: limit_value = $urandom_range(1, DIRECT_DEPTH - 1);
                3: limit_value = 16383;
                4: limit_value = $urandom_range(0, 300);
                default: limit_value = cpsr_pkg::DIRECT_LIMIT_RST;
            endcase
            count_value = (round == 5) ? $urandom_range(1, n) : n;
            // One round runs with no idling on either side.
            tx_gaps_on   = (round != 2);
            rx_stalls_on = (round != 2);
            load_sorted_ranges(n);
            write_config(limit_value, count_value, rand_script());
            random_items(30);
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // Long receiver hold while lookups keep coming, so the input stalls.
    task automatic test_backpressure();
        tx_gaps_on = 1'b0;
        hold_left  = HOLD_CYCLES;
        for (int k = 0; k < 30; k++)
            lookup(($urandom_range(0, 1) == 0) ? rand_cp() : $urandom_range(0, 8191));
        tx_gaps_on = 1'b1;
        drain();
        random_items(20);
    endtask

    // Full-depth searches: saturated count, stale hint, empty count, then unsorted.
    // Beyond the slots loaded earlier, range entries are written mainly where a search will probe.
    task automatic test_full_table();
        // Earlier slots are laid out again so that the table stays sorted.
        for (int i = 0; i < RANGE_DEPTH; i++)
            if (range_loaded[i])
                load_pitch_range(i);
        write_config($urandom_range(0, DIRECT_DEPTH), 4095, rand_script());
        random_items(20);
        write_config(cpsr_pkg::DIRECT_LIMIT_RST, RANGE_DEPTH, 255);
        random_items(10);
        // A hit high in the table leaves a hint beyond a small count.
        load_range(2040, 2040 * RANGE_PITCH, 10, 77);
        lookup(2040 * RANGE_PITCH + 3);
        write_config(cpsr_pkg::DIRECT_LIMIT_RST, 16, cpsr_pkg::UNKNOWN_CODE_RST);
        lookup(int'(range_start_tbl[3]));
        lookup(rand_cp());
        random_items(10);
        write_config(0, 0, 0);
        lookup(0);
        lookup(rand_cp());
        // Random rewrites leave the table unsorted and overlapping.
        write_config(cpsr_pkg::DIRECT_LIMIT_RST, RANGE_DEPTH, rand_script());
        for (int k = 0; k < 20; k++)
            load_range($urandom_range(0, RANGE_DEPTH - 1), rand_cp(), rand_len(),
                       rand_script());
        random_items(20);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_range_edges();
        test_direct_limits();
        test_random_tables();
        test_backpressure();
        test_full_table();
        drain();
        if (mismatches == 0)
            $display("codepoint_script_range_lookup_tb OK");
        else
            $display("codepoint_script_range_lookup_tb NOT OK");
        $finish;
    end

endmodule
